### rtl/tgbe_pkg.sv
// Shared types, constants and the exponential table for the two-Gaussian evaluator.
// Used by every module of the block; has no dependencies of its own.
package tgbe_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int DEPTH_LOG2      = $clog2(EXP_TABLE_DEPTH);
  localparam int FRAC_W          = 20 - DEPTH_LOG2;
  localparam int ROM_IDX_W       = DEPTH_LOG2 + 1;
  localparam int DIFF_W          = ((COORD_WIDTH > 32) ? COORD_WIDTH : 32) + 1;
  localparam int DM_W            = 33;
  localparam int SHAPE_W         = 17;
  localparam int CONTRIB_W       = 50;
  localparam int SLOPE_W         = 58;
  localparam int SP_W            = 32 + COORD_WIDTH;
  localparam int SP_CMP_W        = (SP_W > 57) ? SP_W : 57;
  localparam int SUM_W           = 60;
  localparam int STAGES          = 10;
  localparam int NUM_REGS        = 8;
  localparam int PADDR_W         = $clog2(NUM_REGS * 4);

  localparam logic [DM_W-1:0] DM_LIMIT    = 33'h1_0000_0000;
  localparam logic [56:0]     SLOPE_LIMIT = 57'd1 << 56;

  typedef enum logic [2:0] {
    REG_BG_OFFSET,
    REG_BG_SLOPE,
    REG_FIRST_AMP,
    REG_FIRST_CENTER,
    REG_FIRST_RATE,
    REG_SECOND_AMP,
    REG_SECOND_CENTER,
    REG_SECOND_RATE
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] amp;
    logic signed [31:0] center;
    logic [31:0]        rate;
  } peak_cfg_t;

  typedef struct packed {
    logic signed [31:0] offset;
    logic signed [31:0] slope;
    peak_cfg_t          first;
    peak_cfg_t          second;
  } cfg_t;

  localparam peak_cfg_t PEAK_RESET = '{amp: 32'sd65536, center: 32'sd0, rate: 32'd16777216};
  localparam cfg_t CFG_RESET = '{offset: 32'sd0, slope: 32'sd0,
                                 first: PEAK_RESET, second: PEAK_RESET};

  typedef logic [STAGES:1] stage_en_t;

  typedef logic [32:0] rom_word_t;
  typedef rom_word_t rom_t [EXP_TABLE_DEPTH+1];

  // e^(-16k/DEPTH) in Q.32, Taylor step in Q.59 then repeated products
  function automatic rom_t build_exp_rom();
    rom_t         rom;
    logic [127:0] pr;
    logic [63:0]  term;
    logic [63:0]  v;
    logic [63:0]  step;
    logic [63:0]  acc;
    term = 64'd1 << 59;
    v    = 64'd1 << 59;
    acc  = 64'd1 << 59;
    step = (64'd1 << 63) / EXP_TABLE_DEPTH;
    for (int n = 1; n <= 24; n++) begin
      pr   = {64'd0, term} * {64'd0, step};
      term = pr[122:59] / 64'(n);
      if (n % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      rom[k] = 33'((v + (64'd1 << 26)) >> 27);
      pr     = {64'd0, v} * {64'd0, acc};
      v      = pr[122:59];
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_exp_rom();

endpackage

### rtl/tgbe_regs.sv
// APB-style register file holding background and peak parameters.
// Depends on tgbe_pkg for the register map and the cfg_t layout.
module tgbe_regs import tgbe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_BG_OFFSET:     cfg_d.offset        = pwdata;
        REG_BG_SLOPE:      cfg_d.slope         = pwdata;
        REG_FIRST_AMP:     cfg_d.first.amp     = pwdata;
        REG_FIRST_CENTER:  cfg_d.first.center  = pwdata;
        REG_FIRST_RATE:    cfg_d.first.rate    = pwdata;
        REG_SECOND_AMP:    cfg_d.second.amp    = pwdata;
        REG_SECOND_CENTER: cfg_d.second.center = pwdata;
        REG_SECOND_RATE:   cfg_d.second.rate   = pwdata;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BG_OFFSET:     prdata = cfg_q.offset;
      REG_BG_SLOPE:      prdata = cfg_q.slope;
      REG_FIRST_AMP:     prdata = cfg_q.first.amp;
      REG_FIRST_CENTER:  prdata = cfg_q.first.center;
      REG_FIRST_RATE:    prdata = cfg_q.first.rate;
      REG_SECOND_AMP:    prdata = cfg_q.second.amp;
      REG_SECOND_CENTER: prdata = cfg_q.second.center;
      REG_SECOND_RATE:   prdata = cfg_q.second.rate;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/tgbe_background.sv
// Linear background slope term a1*x, limited to 2^56, delayed to line up with the peaks.
// Depends on tgbe_pkg; advances on the shared stage enables.
module tgbe_background import tgbe_pkg::*; (
  input  logic                          clk_i,
  input  stage_en_t                     en_i,
  input  logic signed [COORD_WIDTH-1:0] coord_i,
  input  logic signed [31:0]            slope_i,
  output logic signed [SLOPE_W-1:0]     slope_term_o
);

  logic [COORD_WIDTH-1:0]    xa_d, xa_q;
  logic                      xneg_q;
  logic [31:0]               aa;
  logic [SP_W-1:0]           prod;
  logic [56:0]               lim;
  logic signed [SLOPE_W-1:0] term_d;
  logic signed [SLOPE_W-1:0] dl_q [2:STAGES-1];

  assign xa_d = coord_i[COORD_WIDTH-1] ? COORD_WIDTH'(-coord_i) : coord_i;
  assign aa   = slope_i[31] ? 32'(-slope_i) : slope_i;
  assign prod = SP_W'(aa) * SP_W'(xa_q);

  always_comb begin
    if (SP_CMP_W'(prod) > SP_CMP_W'(SLOPE_LIMIT)) lim = SLOPE_LIMIT;
    else                                          lim = 57'(prod);
    if (slope_i[31] != xneg_q) term_d = -$signed({1'b0, lim});
    else                       term_d = $signed({1'b0, lim});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      xa_q   <= xa_d;
      xneg_q <= coord_i[COORD_WIDTH-1];
    end
    if (en_i[2]) dl_q[2] <= term_d;
    for (int k = 3; k <= STAGES-1; k++) begin
      if (en_i[k]) dl_q[k] <= dl_q[k-1];
    end
  end

  assign slope_term_o = dl_q[STAGES-1];

endmodule

### rtl/tgbe_peak.sv
// Nine-stage pipeline for one Gaussian peak: shape, rate and center partials, q*g.
// Depends on tgbe_pkg for widths and the exponential table.
module tgbe_peak import tgbe_pkg::*; (
  input  logic                          clk_i,
  input  stage_en_t                     en_i,
  input  logic signed [COORD_WIDTH-1:0] coord_i,
  input  peak_cfg_t                     cfg_i,
  output logic [SHAPE_W-1:0]            shape_o,
  output logic signed [31:0]            rate_partial_o,
  output logic signed [31:0]            center_partial_o,
  output logic signed [CONTRIB_W-1:0]   contrib_o
);

  logic [31:0] amp_mag;
  assign amp_mag = cfg_i.amp[31] ? 32'(-cfg_i.amp) : cfg_i.amp;

  // stage 1: offset from center
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_mag;
  logic [DM_W-1:0]          dm_d, s1_dm_q;
  logic                     s1_neg_q;

  always_comb begin
    diff     = DIFF_W'(coord_i) - DIFF_W'($signed(cfg_i.center));
    diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    if (diff_mag > DIFF_W'(DM_LIMIT)) dm_d = DM_LIMIT;
    else                              dm_d = diff_mag[DM_W-1:0];
  end

  // stage 2: d^2/2 and r*|d|
  logic [64:0] sq, rdp;
  logic [63:0] hs_d, s2_hs_q, s2_rd_q;
  logic        s2_neg_q;

  always_comb begin
    sq   = s1_dm_q * s1_dm_q[32:1];
    hs_d = sq[63:0] + {32'd0, (s1_dm_q[0] ? s1_dm_q[32:1] : 32'd0)};
    rdp  = cfg_i.rate * s1_dm_q;
  end

  // stage 3: split products
  logic [63:0] pt0_d, pt1_d, ph0_d, ph1_d, pr0_d, pr1_d;
  logic [63:0] s3_pt0_q, s3_pt1_q, s3_ph0_q, s3_ph1_q, s3_pr0_q, s3_pr1_q;
  logic        s3_neg_q;

  assign pt0_d = cfg_i.rate * s2_hs_q[31:0];
  assign pt1_d = cfg_i.rate * s2_hs_q[63:32];
  assign ph0_d = amp_mag * s2_hs_q[31:0];
  assign ph1_d = amp_mag * s2_hs_q[63:32];
  assign pr0_d = amp_mag * s2_rd_q[31:0];
  assign pr1_d = amp_mag * s2_rd_q[63:32];

  // stage 4: exponent argument, table index
  logic [95:0]            ptr, qh_d, qrd_d;
  logic [95:0]            s4_qh_q, s4_qrd_q;
  logic [DEPTH_LOG2-1:0]  s4_idx_q;
  logic [FRAC_W-1:0]      s4_frac_q;
  logic                   s4_zero_q, s4_neg_q;

  always_comb begin
    ptr   = {32'd0, s3_pt0_q} + {s3_pt1_q, 32'd0} + (96'd1 << 39);
    qh_d  = {32'd0, s3_ph0_q} + {s3_ph1_q, 32'd0};
    qrd_d = {32'd0, s3_pr0_q} + {s3_pr1_q, 32'd0};
  end

  // stage 5: table read
  logic [ROM_IDX_W-1:0] rom_idx;
  rom_word_t            s5_a_q, s5_b_q;
  logic [FRAC_W-1:0]    s5_frac_q;
  logic [95:0]          s5_qh_q, s5_qrd_q;
  logic                 s5_zero_q, s5_neg_q;

  assign rom_idx = {1'b0, s4_idx_q};

  // stage 6: interpolation
  logic [32:0]          ab;
  logic [33+FRAC_W-1:0] ip;
  logic [32:0]          g32, gr;
  logic [SHAPE_W-1:0]   g_d, s6_g_q;
  logic [95:0]          s6_qh_q, s6_qrd_q;
  logic                 s6_neg_q;

  always_comb begin
    ab  = s5_a_q - s5_b_q;
    ip  = ab * s5_frac_q;
    g32 = s5_a_q - 33'(ip >> FRAC_W);
    gr  = g32 + 33'd32768;
    g_d = s5_zero_q ? '0 : gr[32:16];
  end

  // stage 7: products by the shape
  logic [49:0]        s7_rc0_q;
  logic [48:0]        s7_rc1_q, s7_rc2_q, s7_cc1_q, s7_cc2_q, s7_gq_q;
  logic [55:0]        s7_cc0_q;
  logic [SHAPE_W-1:0] s7_g_q;
  logic               s7_neg_q;
  logic [49:0]        rc0_d;
  logic [48:0]        rc1_d, rc2_d, cc1_d, cc2_d, gq_d;
  logic [55:0]        cc0_d;

  assign rc0_d = s6_g_q * s6_qh_q[31:0] + (50'd1 << 47);
  assign rc1_d = s6_g_q * s6_qh_q[63:32];
  assign rc2_d = s6_g_q * s6_qh_q[95:64];
  assign cc0_d = s6_g_q * s6_qrd_q[31:0] + (56'd1 << 55);
  assign cc1_d = s6_g_q * s6_qrd_q[63:32];
  assign cc2_d = s6_g_q * s6_qrd_q[95:64];
  assign gq_d  = s6_g_q * amp_mag;

  // stage 8: sum partial products
  logic [113:0]       sr_d, sc_d, s8_sr_q, s8_sc_q;
  logic [48:0]        s8_gq_q;
  logic [SHAPE_W-1:0] s8_g_q;
  logic               s8_neg_q;

  assign sr_d = 114'(s7_rc0_q) + 114'({s7_rc1_q, 32'd0}) + 114'({s7_rc2_q, 64'd0});
  assign sc_d = 114'(s7_cc0_q) + 114'({s7_cc1_q, 32'd0}) + 114'({s7_cc2_q, 64'd0});

  // stage 9: saturate and apply signs
  logic [65:0]                rmag, rcap;
  logic [57:0]                cmag, ccap;
  logic [31:0]                rsat, csat;
  logic                       rneg, cneg;
  logic signed [31:0]         rate_d, cen_d;
  logic signed [CONTRIB_W-1:0] contrib_d;

  always_comb begin
    rneg = !cfg_i.amp[31] && (cfg_i.amp != 32'sd0);
    cneg = cfg_i.amp[31] ^ s8_neg_q;
    rmag = s8_sr_q[113:48];
    cmag = s8_sc_q[113:56];
    rcap = rneg ? 66'h8000_0000 : 66'h7FFF_FFFF;
    ccap = cneg ? 58'h8000_0000 : 58'h7FFF_FFFF;
    rsat = (rmag > rcap) ? rcap[31:0] : rmag[31:0];
    csat = (cmag > ccap) ? ccap[31:0] : cmag[31:0];
    rate_d = rneg ? -$signed(rsat) : $signed(rsat);
    cen_d  = cneg ? -$signed(csat) : $signed(csat);
    contrib_d = cfg_i.amp[31] ? -$signed({1'b0, s8_gq_q}) : $signed({1'b0, s8_gq_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s1_dm_q  <= dm_d;
      s1_neg_q <= diff[DIFF_W-1];
    end
    if (en_i[2]) begin
      s2_hs_q  <= hs_d;
      s2_rd_q  <= rdp[63:0];
      s2_neg_q <= s1_neg_q;
    end
    if (en_i[3]) begin
      s3_pt0_q <= pt0_d;
      s3_pt1_q <= pt1_d;
      s3_ph0_q <= ph0_d;
      s3_ph1_q <= ph1_d;
      s3_pr0_q <= pr0_d;
      s3_pr1_q <= pr1_d;
      s3_neg_q <= s2_neg_q;
    end
    if (en_i[4]) begin
      s4_zero_q <= |ptr[95:60];
      s4_idx_q  <= ptr[59:40+FRAC_W];
      s4_frac_q <= ptr[40+FRAC_W-1:40];
      s4_qh_q   <= qh_d;
      s4_qrd_q  <= qrd_d;
      s4_neg_q  <= s3_neg_q;
    end
    if (en_i[5]) begin
      s5_a_q    <= EXP_ROM[rom_idx];
      s5_b_q    <= EXP_ROM[ROM_IDX_W'(rom_idx + 1'b1)];
      s5_frac_q <= s4_frac_q;
      s5_zero_q <= s4_zero_q;
      s5_qh_q   <= s4_qh_q;
      s5_qrd_q  <= s4_qrd_q;
      s5_neg_q  <= s4_neg_q;
    end
    if (en_i[6]) begin
      s6_g_q   <= g_d;
      s6_qh_q  <= s5_qh_q;
      s6_qrd_q <= s5_qrd_q;
      s6_neg_q <= s5_neg_q;
    end
    if (en_i[7]) begin
      s7_rc0_q <= rc0_d;
      s7_rc1_q <= rc1_d;
      s7_rc2_q <= rc2_d;
      s7_cc0_q <= cc0_d;
      s7_cc1_q <= cc1_d;
      s7_cc2_q <= cc2_d;
      s7_gq_q  <= gq_d;
      s7_g_q   <= s6_g_q;
      s7_neg_q <= s6_neg_q;
    end
    if (en_i[8]) begin
      s8_sr_q  <= sr_d;
      s8_sc_q  <= sc_d;
      s8_gq_q  <= s7_gq_q;
      s8_g_q   <= s7_g_q;
      s8_neg_q <= s7_neg_q;
    end
    if (en_i[9]) begin
      shape_o          <= s8_g_q;
      rate_partial_o   <= rate_d;
      center_partial_o <= cen_d;
      contrib_o        <= contrib_d;
    end
  end

endmodule

### rtl/two_gaussian_background_eval_core.sv
// Evaluates a linear background plus two Gaussian peaks, with fit partials.
// Accepts one coordinate beat per clock while in_stall_o is low and presents its result
// beat from the last of the ten pipeline stages; every multiplier is used once per beat.
// A stall holds the filled stages from the output back to the first empty stage, which
// keeps filling. Registers are written through the APB-style port and must only change
// while no beat is in flight. Depends on tgbe_pkg, tgbe_regs, tgbe_background and
// tgbe_peak.
module two_gaussian_background_eval_core import tgbe_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] coord_i,
  input  logic                          last_point_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            model_value_o,
  output logic [SHAPE_W-1:0]            first_shape_o,
  output logic signed [31:0]            first_rate_partial_o,
  output logic signed [31:0]            first_center_partial_o,
  output logic [SHAPE_W-1:0]            second_shape_o,
  output logic signed [31:0]            second_rate_partial_o,
  output logic signed [31:0]            second_center_partial_o,
  output logic                          last_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_W-1:0]            paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam logic signed [SUM_W-17:0] MV_MAX = (SUM_W-16)'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-17:0] MV_MIN = (SUM_W-16)'(32'sh8000_0000);

  cfg_t                        cfg;
  stage_en_t                   en, v_q, v_d, last_q, last_d;
  logic signed [SLOPE_W-1:0]   slope_term;
  logic [SHAPE_W-1:0]          p1_shape, p2_shape;
  logic signed [31:0]          p1_rate, p1_cen, p2_rate, p2_cen;
  logic signed [CONTRIB_W-1:0] p1_contrib, p2_contrib;
  logic signed [SUM_W-1:0]     sum;
  logic signed [SUM_W-17:0]    sum_sh;
  logic signed [31:0]          model_d;

  tgbe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    en = '0;
    en[STAGES] = !v_q[STAGES] || !out_stall_i;
    for (int k = STAGES-1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[1];
  assign v_d         = {v_q[STAGES-1:1], in_valid_i};
  assign last_d      = {last_q[STAGES-1:1], last_point_i};
  assign out_valid_o = v_q[STAGES];
  assign last_out_o  = last_q[STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if (en[k]) v_q[k] <= v_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= STAGES; k++) begin
      if (en[k]) last_q[k] <= last_d[k];
    end
  end

  tgbe_background u_bg (
    .clk_i        (clk_i),
    .en_i         (en),
    .coord_i      (coord_i),
    .slope_i      (cfg.slope),
    .slope_term_o (slope_term)
  );

  tgbe_peak u_peak1 (
    .clk_i            (clk_i),
    .en_i             (en),
    .coord_i          (coord_i),
    .cfg_i            (cfg.first),
    .shape_o          (p1_shape),
    .rate_partial_o   (p1_rate),
    .center_partial_o (p1_cen),
    .contrib_o        (p1_contrib)
  );

  tgbe_peak u_peak2 (
    .clk_i            (clk_i),
    .en_i             (en),
    .coord_i          (coord_i),
    .cfg_i            (cfg.second),
    .shape_o          (p2_shape),
    .rate_partial_o   (p2_rate),
    .center_partial_o (p2_cen),
    .contrib_o        (p2_contrib)
  );

  // Q.32 sum, round half up, saturate
  always_comb begin
    sum = SUM_W'($signed({cfg.offset, 16'd0})) + SUM_W'(slope_term)
        + SUM_W'(p1_contrib) + SUM_W'(p2_contrib) + SUM_W'(32'sd32768);
    sum_sh = (SUM_W-16)'(sum >>> 16);
    if (sum_sh > MV_MAX)      model_d = 32'sh7FFF_FFFF;
    else if (sum_sh < MV_MIN) model_d = 32'sh8000_0000;
    else                      model_d = 32'(sum_sh);
  end

  always_ff @(posedge clk_i) begin
    if (en[STAGES]) begin
      model_value_o           <= model_d;
      first_shape_o           <= p1_shape;
      first_rate_partial_o    <= p1_rate;
      first_center_partial_o  <= p1_cen;
      second_shape_o          <= p2_shape;
      second_rate_partial_o   <= p2_rate;
      second_center_partial_o <= p2_cen;
    end
  end

endmodule

### rtl/tgbe_checker.sv
// Port-level checks for the two-Gaussian evaluator, bound to the top level.
// Depends on tgbe_pkg and two_gaussian_background_eval_core.
module tgbe_checker import tgbe_pkg::*; (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [SHAPE_W-1:0]            first_shape_o,
  input logic signed [31:0]            first_rate_partial_o,
  input logic signed [31:0]            first_center_partial_o,
  input logic [SHAPE_W-1:0]            second_shape_o
);

  // held beat keeps its first-peak shape
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(first_shape_o))
    else $error("stalled beat changed");

  a_shape_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (first_shape_o <= 17'd65536) && (second_shape_o <= 17'd65536))
    else $error("shape above one");

  a_zero_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_shape_o == '0
      |-> first_rate_partial_o == 32'sd0 && first_center_partial_o == 32'sd0)
    else $error("partial nonzero with zero shape");

  // input only backs up behind a full, stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

endmodule

bind two_gaussian_background_eval_core tgbe_checker u_chk (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .in_stall_o             (in_stall_o),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .first_shape_o          (first_shape_o),
  .first_rate_partial_o   (first_rate_partial_o),
  .first_center_partial_o (first_center_partial_o),
  .second_shape_o         (second_shape_o)
);
